// ===== rtl/int8_dot_product_requantize_defines.svh =====
// assertion macros shared by the int8 dot product requantize rtl
`ifndef INT8_DOT_PRODUCT_REQUANTIZE_DEFINES_SVH
`define INT8_DOT_PRODUCT_REQUANTIZE_DEFINES_SVH

// checked on every clock edge outside reset
`define DPR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dot product requantize check failed");

// checked on every clock edge, reset included
`define DPR_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("dot product requantize check failed");

`endif

// ===== rtl/dpr_pkg.sv =====
// shared types and constants for the int8 dot product requantize block
package dpr_pkg;

    localparam int LANES_DEFAULT  = 8;
    localparam int BYTES_PER_WORD = 8;
    localparam int BYTE_W         = 8;
    localparam int WORD_W         = 64;
    localparam int PROD_W         = 16;
    localparam int ACC_W          = 32;
    localparam int MULT_W         = 32;
    localparam int BIAS_W         = 48;
    localparam int PRODUCT_W      = 64;
    localparam int SUM_W          = 65;
    localparam int SHIFT_W        = 6;
    localparam int QUANT_W        = 8;
    localparam int CFG_INDEX_W    = 1;
    localparam int CFG_DATA_W     = 6;

    localparam int QUANT_MAX = 127;
    localparam int QUANT_MIN = -128;

    localparam logic [SHIFT_W-1:0] SCALE_SHIFT_RESET = 6'd31;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RELU_ENABLE = 1'b0,
        REG_SCALE_SHIFT = 1'b1
    } cfg_reg_e;

    typedef struct packed {
        logic [WORD_W-1:0]        act_bytes;
        logic [WORD_W-1:0]        wgt_bytes;
        logic                     last;
        logic [MULT_W-1:0]        scale_mult;
        logic signed [BIAS_W-1:0] bias_term;
    } in_item_t;

    typedef struct packed {
        logic signed [ACC_W-1:0]   raw_sum;
        logic signed [QUANT_W-1:0] quant_value;
    } out_item_t;

    // side fields that ride along with the lane products
    typedef struct packed {
        logic                     last;
        logic [MULT_W-1:0]        scale_mult;
        logic signed [BIAS_W-1:0] bias_term;
    } chunk_ctl_t;

endpackage

// ===== rtl/dpr_lanes.sv =====
// parallel int8 multiplier lanes with their stage register
module dpr_lanes #(
    parameter int LANES = dpr_pkg::LANES_DEFAULT
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  dpr_pkg::in_item_t                        in_item,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic [LANES-1:0][dpr_pkg::PROD_W-1:0]    out_prod,
    output dpr_pkg::chunk_ctl_t                      out_ctl
);
    import dpr_pkg::*;

    logic                           valid_reg;
    logic [LANES-1:0][PROD_W-1:0]   prod_reg;
    logic [LANES-1:0][PROD_W-1:0]   prod_next;
    chunk_ctl_t                     ctl_reg;
    logic                           advance;

    // lanes past the eight bytes of the words see zero
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        if (l < BYTES_PER_WORD) begin : g_real
            logic signed [PROD_W-1:0] lane_prod;
            assign lane_prod = $signed(in_item.act_bytes[BYTE_W*l +: BYTE_W])
                             * $signed(in_item.wgt_bytes[BYTE_W*l +: BYTE_W]);
            assign prod_next[l] = lane_prod;
        end else begin : g_zero
            assign prod_next[l] = '0;
        end
    end

    assign advance  = !valid_reg || !out_stall;
    assign in_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            prod_reg <= prod_next;
            ctl_reg  <= '{last: in_item.last, scale_mult: in_item.scale_mult,
                          bias_term: in_item.bias_term};
        end
    end

    assign out_valid = valid_reg;
    assign out_prod  = prod_reg;
    assign out_ctl   = ctl_reg;

endmodule

// ===== rtl/dpr_merge.sv =====
// merging adder over the lane products and the wrapping accumulator
`include "int8_dot_product_requantize_defines.svh"

module dpr_merge #(
    parameter int LANES = dpr_pkg::LANES_DEFAULT
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic [LANES-1:0][dpr_pkg::PROD_W-1:0]    in_prod,
    input  dpr_pkg::chunk_ctl_t                      in_ctl,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic signed [dpr_pkg::ACC_W-1:0]         out_sum,
    output logic [dpr_pkg::MULT_W-1:0]               out_mult,
    output logic signed [dpr_pkg::BIAS_W-1:0]        out_bias
);
    import dpr_pkg::*;

    logic [ACC_W-1:0]         acc_reg;
    logic [ACC_W-1:0]         acc_next;
    logic [ACC_W-1:0]         sum;
    logic                     valid_reg;
    logic [ACC_W-1:0]         sum_reg;
    logic [MULT_W-1:0]        mult_reg;
    logic signed [BIAS_W-1:0] bias_reg;
    logic                     advance;
    logic                     take;

    always_comb
    begin
        sum = acc_reg;
        for (int l = 0; l < LANES; l++)
        begin
            sum = sum + ACC_W'($signed(in_prod[l]));
        end
    end

    assign advance  = !valid_reg || !out_stall;
    assign in_stall = !advance;
    assign take     = in_valid && advance;
    assign acc_next = in_ctl.last ? '0 : sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                acc_reg <= acc_next;
            end
            if (advance)
            begin
                // only a closing chunk moves on to requantization
                valid_reg <= take && in_ctl.last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && in_ctl.last)
        begin
            sum_reg  <= sum;
            mult_reg <= in_ctl.scale_mult;
            bias_reg <= in_ctl.bias_term;
        end
    end

    assign out_valid = valid_reg;
    assign out_sum   = $signed(sum_reg);
    assign out_mult  = mult_reg;
    assign out_bias  = bias_reg;

    `DPR_ASSERT(a_acc_clear_on_last, take && in_ctl.last |=> acc_reg == '0)
    `DPR_ASSERT(a_stall_only_when_full, in_stall |-> valid_reg && out_stall)

endmodule

// ===== rtl/dpr_requant.sv =====
// requantization pipeline: scale multiply, bias add, rounding shift, saturation
`include "int8_dot_product_requantize_defines.svh"

module dpr_requant (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 relu_enable,
    input  logic [dpr_pkg::SHIFT_W-1:0]          scale_shift,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [dpr_pkg::ACC_W-1:0]     in_sum,
    input  logic [dpr_pkg::MULT_W-1:0]           in_mult,
    input  logic signed [dpr_pkg::BIAS_W-1:0]    in_bias,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output dpr_pkg::out_item_t                   out_item
);
    import dpr_pkg::*;

    logic                        mul_valid_reg;
    logic signed [PRODUCT_W-1:0] mul_prod_reg;
    logic signed [BIAS_W-1:0]    mul_bias_reg;
    logic signed [ACC_W-1:0]     mul_raw_reg;

    logic                        add_valid_reg;
    logic signed [SUM_W-1:0]     add_sum_reg;
    logic signed [ACC_W-1:0]     add_raw_reg;

    logic                        sh_valid_reg;
    logic signed [SUM_W-1:0]     sh_q_reg;
    logic                        sh_round_reg;
    logic signed [ACC_W-1:0]     sh_raw_reg;

    logic                        out_valid_reg;
    out_item_t                   out_item_reg;

    logic adv_mul, adv_add, adv_sh, adv_out;

    logic signed [MULT_W:0]      mult_s;
    logic signed [SUM_W-1:0]     prod_full;
    logic signed [SUM_W-1:0]     add_sum_next;
    logic [SHIFT_W-1:0]          sh_m1;
    logic [SUM_W-1:0]            sticky_mask;
    logic signed [SUM_W-1:0]     shifted;
    logic                        round_bit;
    logic                        sticky;
    logic                        round_next;
    logic signed [SUM_W-1:0]     rounded;
    logic signed [QUANT_W-1:0]   quant_next;

    assign adv_out  = !out_valid_reg || !out_stall;
    assign adv_sh   = !sh_valid_reg  || adv_out;
    assign adv_add  = !add_valid_reg || adv_sh;
    assign adv_mul  = !mul_valid_reg || adv_add;
    assign in_stall = !adv_mul;

    // signed sum times unsigned multiplier, exact in 64 bits
    assign mult_s    = $signed({1'b0, in_mult});
    assign prod_full = in_sum * mult_s;

    always_comb
    begin
        add_sum_next = SUM_W'(mul_prod_reg) + SUM_W'(mul_bias_reg);
        if (relu_enable && add_sum_next[SUM_W-1])
        begin
            add_sum_next = '0;
        end
    end

    // round half to even: round bit set and either sticky bits or an odd quotient
    assign sh_m1       = scale_shift - 1'b1;
    assign shifted     = add_sum_reg >>> scale_shift;
    assign round_bit   = add_sum_reg[sh_m1];
    assign sticky_mask = (SUM_W'(1) << sh_m1) - SUM_W'(1);
    assign sticky      = |(add_sum_reg & sticky_mask);
    assign round_next  = (scale_shift != '0) && round_bit && (sticky || shifted[0]);

    always_comb
    begin
        rounded = sh_q_reg + SUM_W'({1'b0, sh_round_reg});
        if (rounded > QUANT_MAX)
        begin
            quant_next = QUANT_W'(QUANT_MAX);
        end
        else if (rounded < QUANT_MIN)
        begin
            quant_next = QUANT_W'(QUANT_MIN);
        end
        else
        begin
            quant_next = rounded[QUANT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            add_valid_reg <= 1'b0;
            sh_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_mul)
            begin
                mul_valid_reg <= in_valid;
            end
            if (adv_add)
            begin
                add_valid_reg <= mul_valid_reg;
            end
            if (adv_sh)
            begin
                sh_valid_reg <= add_valid_reg;
            end
            if (adv_out)
            begin
                out_valid_reg <= sh_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_mul && in_valid)
        begin
            mul_prod_reg <= prod_full[PRODUCT_W-1:0];
            mul_bias_reg <= in_bias;
            mul_raw_reg  <= in_sum;
        end
        if (adv_add && mul_valid_reg)
        begin
            add_sum_reg <= add_sum_next;
            add_raw_reg <= mul_raw_reg;
        end
        if (adv_sh && add_valid_reg)
        begin
            sh_q_reg     <= shifted;
            sh_round_reg <= round_next;
            sh_raw_reg   <= add_raw_reg;
        end
        if (adv_out && sh_valid_reg)
        begin
            out_item_reg <= '{raw_sum: sh_raw_reg, quant_value: quant_next};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `DPR_ASSERT(a_mul_moves_on, mul_valid_reg && adv_add |=> add_valid_reg)

endmodule

// ===== rtl/int8_dot_product_requantize.sv =====
// a last chunk's result passes the lane, merge, multiply, add, shift and output registers
// throughput: one chunk per cycle while item_stall is low, one result per chunk marked last
// the accumulator loop closes in the merge stage, so chunks stream with no gap
// the result sits in an output register; input stalls only when that register is full and stalled
// reset: async active low, clears all valids and the accumulator, relu off, shift 31
// top level of the int8 dot product with fixed-point requantization
`include "int8_dot_product_requantize_defines.svh"

module int8_dot_product_requantize #(
    parameter int LANES = dpr_pkg::LANES_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write port
    input  logic                                  cfg_we,
    input  logic [dpr_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [dpr_pkg::CFG_DATA_W-1:0]        cfg_data,
    // chunk transactions
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  dpr_pkg::in_item_t                     item,
    // result transactions
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output dpr_pkg::out_item_t                    result
);
    import dpr_pkg::*;

    // configuration registers
    logic               relu_enable_reg;
    logic [SHIFT_W-1:0] scale_shift_reg;

    // lanes to merge
    logic                         lanes_valid;
    logic                         lanes_stall;
    logic [LANES-1:0][PROD_W-1:0] lanes_prod;
    chunk_ctl_t                   lanes_ctl;

    // merge to requantization
    logic                         merge_valid;
    logic                         merge_stall;
    logic signed [ACC_W-1:0]      merge_sum;
    logic [MULT_W-1:0]            merge_mult;
    logic signed [BIAS_W-1:0]     merge_bias;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relu_enable_reg <= 1'b0;
            scale_shift_reg <= SCALE_SHIFT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_e'(cfg_index))
                REG_RELU_ENABLE: relu_enable_reg <= cfg_data[0];
                REG_SCALE_SHIFT: scale_shift_reg <= cfg_data[SHIFT_W-1:0];
            endcase
        end
    end

    // eight int8 multipliers side by side, one product register each
    dpr_lanes #(
        .LANES (LANES)
    ) u_lanes (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_valid),
        .in_stall  (item_stall),
        .in_item   (item),
        .out_valid (lanes_valid),
        .out_stall (lanes_stall),
        .out_prod  (lanes_prod),
        .out_ctl   (lanes_ctl)
    );

    // sum of the lanes into the wrapping accumulator; last chunk hands off the total
    dpr_merge #(
        .LANES (LANES)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lanes_valid),
        .in_stall  (lanes_stall),
        .in_prod   (lanes_prod),
        .in_ctl    (lanes_ctl),
        .out_valid (merge_valid),
        .out_stall (merge_stall),
        .out_sum   (merge_sum),
        .out_mult  (merge_mult),
        .out_bias  (merge_bias)
    );

    // multiply, bias add with relu, rounding shift, saturation into the output register
    dpr_requant u_requant (
        .clk         (clk),
        .rst_n       (rst_n),
        .relu_enable (relu_enable_reg),
        .scale_shift (scale_shift_reg),
        .in_valid    (merge_valid),
        .in_stall    (merge_stall),
        .in_sum      (merge_sum),
        .in_mult     (merge_mult),
        .in_bias     (merge_bias),
        .out_valid   (result_valid),
        .out_stall   (result_stall),
        .out_item    (result)
    );

    `DPR_ASSERT_ALWAYS(a_input_stall_needs_full_output, item_stall |-> result_valid && result_stall)

endmodule

// ===== tb/tb_int8_dot_product_requantize.sv =====
// self-checking testbench for the int8 dot product with fixed-point requantization
module tb_int8_dot_product_requantize;
    import dpr_pkg::*;

    // cycles to let the pipeline settle once nothing is pending
    localparam int DRAIN_CYCLES = 10;
    // chunks per long accumulation chain
    localparam int CHAIN_CHUNKS = 24;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   item_valid;
    logic                   item_stall;
    in_item_t               item;
    logic                   result_valid;
    logic                   result_stall;
    out_item_t              result;

    // predictor state: running dot product and the register copies
    logic [ACC_W-1:0]       running_sum = '0;
    logic                   relu_on = 1'b0;
    logic [SHIFT_W-1:0]     shift_amt = SCALE_SHIFT_RESET;
    out_item_t              pending_outputs[$];

    // idling controls for the sender and the receiver, and the mismatch count
    int tx_max_gap = 0;
    int burst_left = 0;
    int rx_stall_pct = 0;
    int rx_hold_cycles = 0;
    int mismatch_count = 0;

    int8_dot_product_requantize u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // exact sum of the eight signed lane products, wrapped to 32 bits
    function automatic logic [ACC_W-1:0] chunk_dot(logic [WORD_W-1:0] act,
                                                   logic [WORD_W-1:0] wgt);
        int acc;
        int i;
        acc = 0;
        for (i = 0; i < BYTES_PER_WORD; i++)
            acc += int'(signed'(act[8*i +: 8])) * int'(signed'(wgt[8*i +: 8]));
        return acc;
    endfunction

    // acc * mult + bias kept exact in 72 bits, then relu, round-half-even shift, saturate
    function automatic logic signed [QUANT_W-1:0] requantize_sum(
        logic signed [ACC_W-1:0]  acc,
        logic [MULT_W-1:0]        mult,
        logic signed [BIAS_W-1:0] bias
    );
        logic signed [71:0] acc_w;
        logic signed [71:0] mult_w;
        logic signed [71:0] bias_w;
        logic signed [71:0] total;
        logic signed [71:0] q;
        logic [71:0]        mask;
        logic [71:0]        rem;
        logic [71:0]        half;
        acc_w  = acc;
        mult_w = {40'd0, mult};
        bias_w = bias;
        total  = acc_w * mult_w + bias_w;
        // rectify before the shift
        if (relu_on && total < 0)
            total = '0;
        if (shift_amt == '0)
            q = total;
        else
        begin
            q    = total >>> shift_amt;
            mask = (72'd1 << shift_amt) - 72'd1;
            rem  = total & mask;
            half = 72'd1 << (shift_amt - 1);
            // ties go to the even neighbour
            if (rem > half || (rem == half && q[0]))
                q = q + 1;
        end
        if (q > QUANT_MAX)
            return QUANT_W'(QUANT_MAX);
        if (q < QUANT_MIN)
            return QUANT_W'(QUANT_MIN);
        return q[QUANT_W-1:0];
    endfunction

    // fold one accepted chunk into the running sum; a last chunk yields a result
    task automatic absorb_chunk(input in_item_t c);
        logic [ACC_W-1:0] total;
        out_item_t        r;
        total = running_sum + chunk_dot(c.act_bytes, c.wgt_bytes);
        if (c.last)
        begin
            r.raw_sum     = total;
            r.quant_value = requantize_sum(total, c.scale_mult, c.bias_term);
            pending_outputs.push_back(r);
            running_sum = '0;
        end
        else
            running_sum = total;
    endtask

    // ------------------------------------------------------------------
    // result checking: every accepted result transaction against the oldest prediction
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_outputs.size() == 0)
            begin
                $error("result transaction with nothing pending: raw_sum %0d quant_value %0d",
                       result.raw_sum, result.quant_value);
                mismatch_count++;
            end
            else
            begin
                want = pending_outputs.pop_front();
                if (result.raw_sum !== want.raw_sum)
                begin
                    $error("raw_sum mismatch: expected %0d, got %0d",
                           want.raw_sum, result.raw_sum);
                    mismatch_count++;
                end
                if (result.quant_value !== want.quant_value)
                begin
                    $error("quant_value mismatch: expected %0d, got %0d",
                           want.quant_value, result.quant_value);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stall runs, or a long counted hold-off on request
    // ------------------------------------------------------------------

    initial
    begin : result_stall_driver
        int n;
        result_stall = 1'b0;
        @(negedge clk);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                n = rx_hold_cycles;
                rx_hold_cycles = 0;
                result_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            else if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(negedge clk);
            end
            else
            begin
                result_stall <= 1'b0;
                @(negedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // sender side; every task starts and ends just after a falling edge
    // ------------------------------------------------------------------

    // offer one chunk transaction and hold it until accepted; valid stays high
    task automatic send_chunk(input in_item_t c);
        item       <= c;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        absorb_chunk(c);
        @(negedge clk);
    endtask

    // drop valid while idling, with garbage on the payload meanwhile
    task automatic idle_sender(input int n);
        in_item_t junk;
        if (n == 0)
            return;
        junk.act_bytes  = {$urandom, $urandom};
        junk.wgt_bytes  = {$urandom, $urandom};
        junk.last       = 1'($urandom_range(0, 1));
        junk.scale_mult = $urandom;
        junk.bias_term  = BIAS_W'({$urandom, $urandom});
        item_valid <= 1'b0;
        item       <= junk;
        repeat (n) @(negedge clk);
    endtask

    // bursts of random length separated by random gaps
    task automatic offer_chunk(input in_item_t c);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if (tx_max_gap > 0)
                idle_sender($urandom_range(0, tx_max_gap));
        end
        burst_left--;
        send_chunk(c);
    endtask

    task automatic push_chunk(input logic [WORD_W-1:0] act, input logic [WORD_W-1:0] wgt,
                              input logic last, input logic [MULT_W-1:0] mult,
                              input logic signed [BIAS_W-1:0] bias);
        in_item_t c;
        c.act_bytes  = act;
        c.wgt_bytes  = wgt;
        c.last       = last;
        c.scale_mult = mult;
        c.bias_term  = bias;
        offer_chunk(c);
    endtask

    // stop sending until every predicted result is back and the pipeline is empty
    task automatic wait_idle();
        item_valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        burst_left = 0;
    endtask

    // register write; only called while the block is idle
    task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_RELU_ENABLE: relu_on = val[0];
            REG_SCALE_SHIFT: shift_amt = val;
            default: ;
        endcase
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // random content
    // ------------------------------------------------------------------

    // only lane 0 carries a value
    function automatic logic [WORD_W-1:0] lane0(input int v);
        return {56'd0, 8'(v)};
    endfunction

    function automatic logic [WORD_W-1:0] random_lanes();
        logic [WORD_W-1:0] w;
        int                i;
        int                sel;
        w   = {$urandom, $urandom};
        sel = $urandom_range(0, 3);
        if (sel == 2)
        begin
            // byte extremes in every lane
            for (i = 0; i < BYTES_PER_WORD; i++)
                case ($urandom_range(0, 3))
                    0: w[8*i +: 8] = 8'h80;
                    1: w[8*i +: 8] = 8'h7F;
                    2: w[8*i +: 8] = 8'hFF;
                    default: w[8*i +: 8] = 8'h00;
                endcase
        end
        else if (sel == 3)
        begin
            // small values keep the sum near zero
            for (i = 0; i < BYTES_PER_WORD; i++)
                w[8*i +: 8] = 8'($urandom_range(0, 8)) - 8'd4;
        end
        return w;
    endfunction

    // each lane in base..base+3
    function automatic logic [WORD_W-1:0] clustered_lanes(input logic [7:0] base);
        logic [WORD_W-1:0] w;
        int                i;
        for (i = 0; i < BYTES_PER_WORD; i++)
            w[8*i +: 8] = base + 8'($urandom_range(0, 3));
        return w;
    endfunction

    function automatic logic [MULT_W-1:0] random_mult();
        logic [95:0] wide;
        case ($urandom_range(0, 5)) inside
            0: return $urandom;
            1, 2:
            begin
                // scaled to the current shift so the output often lands in range
                wide = 96'($urandom) << shift_amt;
                return wide[68:37];
            end
            3: return $urandom >> $urandom_range(0, 31);
            default:
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return 32'd1;
                    2: return 32'hFFFF_FFFF;
                    default: return 32'h8000_0000;
                endcase
        endcase
    endfunction

    function automatic logic signed [BIAS_W-1:0] random_bias();
        logic [63:0]        bits;
        logic signed [8:0]  steps;
        logic signed [15:0] jitter;
        logic signed [71:0] wide;
        bits = {$urandom, $urandom};
        case ($urandom_range(0, 5)) inside
            0: return bits[47:0];
            1, 2:
            begin
                // a few output steps at the current shift, plus some fraction
                steps  = bits[8:0];
                jitter = bits[63:48];
                wide   = steps;
                wide   = (wide <<< shift_amt) + jitter;
                return wide[47:0];
            end
            3: return signed'(bits[47:0]) >>> $urandom_range(0, 47);
            default:
                case ($urandom_range(0, 3))
                    0: return 48'sh7FFF_FFFF_FFFF;
                    1: return 48'sh8000_0000_0000;
                    2: return '0;
                    default: return '1;
                endcase
        endcase
    endfunction

    function automatic in_item_t random_chunk(input logic last);
        in_item_t c;
        c.act_bytes  = random_lanes();
        c.wgt_bytes  = random_lanes();
        c.last       = last;
        c.scale_mult = random_mult();
        c.bias_term  = random_bias();
        return c;
    endfunction

    // mostly well-formed chains ending in a last chunk, some noise with random last
    task automatic run_random_traffic(input int n_items);
        int       sent;
        int       chain_len;
        int       k;
        in_item_t c;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                chain_len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40)
                                                        : $urandom_range(1, 4);
                for (k = 0; k < chain_len; k++)
                    offer_chunk(random_chunk(k == chain_len - 1));
                sent += chain_len;
            end
            else
            begin
                c = random_chunk(1'($urandom_range(0, 1)));
                c.act_bytes = {$urandom, $urandom};
                c.wgt_bytes = {$urandom, $urandom};
                offer_chunk(c);
                sent++;
            end
        end
    endtask

    task automatic random_phase(input logic relu, input logic [CFG_DATA_W-1:0] shift,
                                input int gap, input int stall_pct, input int n_items);
        wait_idle();
        write_reg(REG_RELU_ENABLE, {5'd0, relu});
        write_reg(REG_SCALE_SHIFT, shift);
        tx_max_gap   = gap;
        rx_stall_pct = stall_pct;
        run_random_traffic(n_items);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // no register writes yet: relu off, shift 31
    task automatic test_reset_defaults();
        tx_max_gap   = 2;
        rx_stall_pct = 30;
        push_chunk('0, '0, 1'b1, '0, '0);
        push_chunk({8{8'h80}}, {8{8'h80}}, 1'b1, 32'hFFFF_FFFF, 48'sh7FFF_FFFF_FFFF);
        push_chunk({8{8'h80}}, {8{8'h7F}}, 1'b1, 32'hFFFF_FFFF, 48'sh8000_0000_0000);
    endtask

    // scale and bias of non-last chunks must be ignored
    task automatic test_multi_chunk();
        push_chunk(lane0(100), lane0(1), 1'b0, 32'hFFFF_FFFF, 48'sh8000_0000_0000);
        push_chunk(lane0(-50), lane0(1), 1'b0, '0, 48'sh7FFF_FFFF_FFFF);
        push_chunk(lane0(3), lane0(-2), 1'b1, 32'h8000_0000, '0);
    endtask

    // shift of zero: the exact sum saturates with no rounding
    task automatic test_shift_zero();
        wait_idle();
        write_reg(REG_SCALE_SHIFT, 6'd0);
        push_chunk(lane0(5), lane0(1), 1'b1, 32'd1, '0);
        push_chunk(lane0(-7), lane0(1), 1'b1, 32'd1, '0);
        push_chunk(lane0(100), lane0(1), 1'b1, 32'd2, -48'sd10);
        push_chunk('0, '0, 1'b1, 32'd1, -48'sd300);
    endtask

    // exact halves go to the even neighbour, from the product and from the bias
    task automatic test_round_half_even();
        wait_idle();
        write_reg(REG_SCALE_SHIFT, 6'd1);
        push_chunk(lane0(1), lane0(1), 1'b1, 32'd1, '0);
        push_chunk(lane0(3), lane0(1), 1'b1, 32'd1, '0);
        push_chunk(lane0(5), lane0(1), 1'b1, 32'd1, '0);
        push_chunk(lane0(-3), lane0(1), 1'b1, 32'd1, '0);
        push_chunk(lane0(-5), lane0(1), 1'b1, 32'd1, '0);
        wait_idle();
        write_reg(REG_SCALE_SHIFT, 6'd4);
        push_chunk('0, '0, 1'b1, '0, 48'sd24);
        push_chunk('0, '0, 1'b1, '0, 48'sd40);
        push_chunk('0, '0, 1'b1, '0, -48'sd24);
    endtask

    // negative sums clamp to zero before the shift; bias can lift a negative product
    task automatic test_relu_clamp();
        wait_idle();
        write_reg(REG_RELU_ENABLE, 6'd1);
        write_reg(REG_SCALE_SHIFT, 6'd1);
        push_chunk(lane0(-3), lane0(1), 1'b1, 32'd1, '0);
        push_chunk(lane0(7), lane0(1), 1'b1, 32'd1, '0);
        push_chunk(lane0(-1), lane0(1), 1'b1, 32'd1, 48'sd10);
        push_chunk({8{8'h80}}, {8{8'h7F}}, 1'b1, 32'hFFFF_FFFF, '0);
    endtask

    task automatic test_shift_max();
        wait_idle();
        write_reg(REG_RELU_ENABLE, 6'd0);
        write_reg(REG_SCALE_SHIFT, 6'd63);
        push_chunk({8{8'h80}}, {8{8'h80}}, 1'b1, 32'hFFFF_FFFF, 48'sh7FFF_FFFF_FFFF);
        push_chunk({8{8'h80}}, {8{8'h7F}}, 1'b1, 32'hFFFF_FFFF, 48'sh8000_0000_0000);
    endtask

    // long chains of near-extreme products build large sums of both signs
    task automatic test_long_chains();
        int       k;
        in_item_t c;
        wait_idle();
        write_reg(REG_SCALE_SHIFT, SCALE_SHIFT_RESET);
        tx_max_gap   = 0;
        rx_stall_pct = 0;
        for (k = 0; k < CHAIN_CHUNKS; k++)
        begin
            c = random_chunk(k == CHAIN_CHUNKS - 1);
            c.act_bytes = clustered_lanes(8'h80);
            c.wgt_bytes = clustered_lanes(8'h80);
            if (c.last)
            begin
                c.scale_mult = 32'h8000_0000;
                c.bias_term  = '0;
            end
            offer_chunk(c);
        end
        for (k = 0; k < CHAIN_CHUNKS; k++)
        begin
            c = random_chunk(k == CHAIN_CHUNKS - 1);
            c.act_bytes = clustered_lanes(8'h80);
            c.wgt_bytes = clustered_lanes(8'd124);
            offer_chunk(c);
        end
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_output_backpressure();
        int k;
        wait_idle();
        write_reg(REG_SCALE_SHIFT, 6'd24);
        tx_max_gap     = 0;
        rx_stall_pct   = 0;
        rx_hold_cycles = 150;
        @(negedge clk);
        for (k = 0; k < 40; k++)
            offer_chunk(random_chunk($urandom_range(0, 3) != 0));
        // sender pauses until every result transaction has drained
        wait_idle();
        rx_stall_pct = 60;
        for (k = 0; k < 30; k++)
            offer_chunk(random_chunk(1'($urandom_range(0, 1))));
    endtask

    // several register settings, extremes included, with varied idling on both sides
    task automatic test_random_traffic();
        random_phase(1'b0, 6'd31, 0, 0, 66);
        random_phase(1'b1, 6'd0, 3, 25, 66);
        random_phase(1'b0, 6'd63, 6, 50, 66);
        random_phase(1'b1, 6'd16, 2, 10, 66);
        random_phase(1'b0, 6'd8, 4, 40, 66);
        random_phase(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
                     $urandom_range(0, 5), $urandom_range(0, 60), 66);
        random_phase(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
                     $urandom_range(0, 5), $urandom_range(0, 60), 66);
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_RELU_ENABLE;
        cfg_data   = '0;
        item_valid = 1'b0;
        item       = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (3) @(negedge clk);

        test_reset_defaults();
        test_multi_chunk();
        test_shift_zero();
        test_round_half_even();
        test_relu_clamp();
        test_shift_max();
        test_long_chains();
        test_output_backpressure();
        test_random_traffic();

        wait_idle();
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial
    begin
        #6000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== int8_dot_product_requantize.f =====
+incdir+rtl
rtl/dpr_pkg.sv
rtl/dpr_lanes.sv
rtl/dpr_merge.sv
rtl/dpr_requant.sv
rtl/int8_dot_product_requantize.sv
tb/tb_int8_dot_product_requantize.sv
